/* rtl/core/ipds_pkg.sv */
package ipds_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int POS_BITS    = 24;
	localparam int CNT_BITS    = POS_BITS + 1;
	localparam int HEAD_DEPTH  = MAX_PATTERN - 1;
	localparam int PTR_BITS    = $clog2(HEAD_DEPTH);
	localparam int LEN_BITS    = 6;
	localparam int CFG_BITS    = 64;
	localparam int IDX_BITS    = 2;

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	typedef enum logic [IDX_BITS-1:0] {
		REG_MASKS_LOW  = 2'd0,
		REG_MASKS_HIGH = 2'd1,
		REG_LENGTH     = 2'd2,
		REG_CIRCULAR   = 2'd3
	} reg_index_t;

	// nucleotide sets, bit 0 = A, 1 = C, 2 = G, 3 = T
	localparam logic [3:0] SET_NONE = 4'h0;
	localparam logic [3:0] SET_A    = 4'h1;
	localparam logic [3:0] SET_C    = 4'h2;
	localparam logic [3:0] SET_G    = 4'h4;
	localparam logic [3:0] SET_T    = 4'h8;
	localparam logic [3:0] SET_AG   = SET_A | SET_G;
	localparam logic [3:0] SET_CT   = SET_C | SET_T;
	localparam logic [3:0] SET_CG   = SET_C | SET_G;
	localparam logic [3:0] SET_AT   = SET_A | SET_T;
	localparam logic [3:0] SET_GT   = SET_G | SET_T;
	localparam logic [3:0] SET_AC   = SET_A | SET_C;
	localparam logic [3:0] SET_CGT  = SET_C | SET_G | SET_T;
	localparam logic [3:0] SET_AGT  = SET_A | SET_G | SET_T;
	localparam logic [3:0] SET_ACT  = SET_A | SET_C | SET_T;
	localparam logic [3:0] SET_ACG  = SET_A | SET_C | SET_G;
	localparam logic [3:0] SET_ACGT = SET_A | SET_C | SET_G | SET_T;

	typedef struct packed {
		logic [7:0] base_char;
		logic       last_base;
	} base_t;

	typedef struct packed {
		logic                hit;
		logic [POS_BITS-1:0] start_position;
		logic                run_done;
		logic                length_overflow;
	} result_t;

	typedef struct packed {
		logic       en;
		logic [3:0] sym;
	} cell_cfg_t;

	function automatic logic [3:0] base_set(input logic [7:0] ch);
		logic [7:0] up;
		up = ch;
		if (ch >= 8'h61 && ch <= 8'h7a)
			up = ch - 8'h20;
		unique case (up)
			8'h41:        base_set = SET_A;    // A
			8'h43:        base_set = SET_C;    // C
			8'h47:        base_set = SET_G;    // G
			8'h54, 8'h55: base_set = SET_T;    // T, U
			8'h52:        base_set = SET_AG;   // R
			8'h59:        base_set = SET_CT;   // Y
			8'h53:        base_set = SET_CG;   // S
			8'h57:        base_set = SET_AT;   // W
			8'h4b:        base_set = SET_GT;   // K
			8'h4d:        base_set = SET_AC;   // M
			8'h42:        base_set = SET_CGT;  // B
			8'h44:        base_set = SET_AGT;  // D
			8'h48:        base_set = SET_ACT;  // H
			8'h56:        base_set = SET_ACG;  // V
			8'h4e:        base_set = SET_ACGT; // N
			default:      base_set = SET_NONE;
		endcase
	endfunction

endpackage

/* rtl/core/ipds_cell.sv */
module ipds_cell import ipds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [3:0] mask_in,
	input  cell_cfg_t  cfg,
	output logic [3:0] mask,
	output logic       ok
);

	logic [3:0] mask_q;
	cell_cfg_t  cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			cfg_q  <= '0;
		end else begin
			cfg_q <= cfg;
			if (clear)
				mask_q <= '0;
			else if (shift)
				mask_q <= mask_in;
		end
	end

	assign mask = mask_q;
	assign ok   = !cfg_q.en || ((mask_q != SET_NONE) && ((mask_q & ~cfg_q.sym) == SET_NONE));

endmodule

/* rtl/core/iupac_degenerate_pattern_search.sv */
// IUPAC pattern search over a stream of ASCII bases.
// Input channel base/base_valid/base_ready takes one base per word; last_base
// ends the sequence. Output channel result/result_valid/result_ready gives one
// word per matching start position and a closing word (run_done) per sequence.
// The user must load the pattern through cfg_we/cfg_index/cfg_data while idle;
// the block does not enforce it. A base accepted shifts into a row of 32 compare
// cells; all cells check the window at once and a hit is registered into the
// output register once that register is free. One base per cycle is taken as
// long as results drain.
// After the last base of a circular sequence whose count did not overflow, the
// head store feeds the first bases back into the cell row, one per cycle while
// the compare stage has room, active pattern length - 1 times (31 at most), to
// check windows that wrap the origin; then the closing word follows.
// Input is held off from the last base until the closing word is registered.
// A stalled receiver holds the output register; bases that miss keep flowing,
// but a hit waiting in the compare stage drops base_ready.
// Reset clears the window, count and pattern registers (length 1, linear);
// the block is ready for bases as soon as reset is released.
module iupac_degenerate_pattern_search import ipds_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                base_valid,
	output logic                base_ready,
	input  base_t               base,
	output logic                result_valid,
	input  logic                result_ready,
	output result_t             result,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_WRAP,
		ST_CLOSE
	} state_t;

	state_t state_q;

	logic [CFG_BITS-1:0] masks_low_q, masks_high_q;
	logic [LEN_BITS-1:0] pat_len_q;
	logic                circular_q;

	logic [CNT_BITS-1:0] count_q, len_q;
	logic                ovf_q;
	logic [3:0]          head_q [HEAD_DEPTH];
	logic [PTR_BITS-1:0] ptr_q, wrap_left_q;

	logic                valid_s1, elig_s1, ovf_s1;
	logic [POS_BITS-1:0] pos_s1;

	logic                out_valid_q;
	result_t             out_q;

	logic [LEN_BITS-1:0] act_len, len_m1;
	logic [2*CFG_BITS-1:0] pat_all;
	cell_cfg_t           cell_cfg [MAX_PATTERN];
	logic [3:0]          cell_mask [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_ok;

	logic acc, wrap_issue, shift, clear_seq, close_fire;
	logic match, hit_s1, out_free, s1_go, s1_room;
	logic [3:0] bmask, shift_mask;
	logic ovf_next, wrap_en;
	logic [CNT_BITS-1:0] count_next, idx_p1, pos_full, ptr_p1;
	logic elig_new;
	logic [POS_BITS-1:0] pos_new;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_low_q  <= '0;
			masks_high_q <= '0;
			pat_len_q    <= LEN_BITS'(1);
			circular_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_MASKS_LOW:  masks_low_q  <= cfg_data;
				REG_MASKS_HIGH: masks_high_q <= cfg_data;
				REG_LENGTH:     pat_len_q    <= cfg_data[LEN_BITS-1:0];
				REG_CIRCULAR:   circular_q   <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	assign act_len = (pat_len_q > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : pat_len_q;
	assign len_m1  = act_len - LEN_BITS'(1);
	assign pat_all = {masks_high_q, masks_low_q};

	// cell i holds the base of age i and compares it against symbol m-1-i
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			logic [LEN_BITS-1:0] k;
			k = len_m1 - LEN_BITS'(i);
			cell_cfg[i].en  = LEN_BITS'(i) < act_len;
			cell_cfg[i].sym = pat_all[{k[PTR_BITS-1:0], 2'b00} +: 4];
		end
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		ipds_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.clear   (clear_seq),
			.mask_in ((i == 0) ? shift_mask : cell_mask[(i == 0) ? 0 : i - 1]),
			.cfg     (cell_cfg[i]),
			.mask    (cell_mask[i]),
			.ok      (cell_ok[i])
		);
	end

	assign match    = &cell_ok;
	assign hit_s1   = valid_s1 && elig_s1 && match;
	assign out_free = !out_valid_q || result_ready;
	assign s1_go    = valid_s1 && (!hit_s1 || out_free);
	assign s1_room  = !valid_s1 || s1_go;

	assign base_ready = (state_q == ST_RUN) && s1_room;
	assign acc        = base_valid && base_ready;
	assign wrap_issue = (state_q == ST_WRAP) && s1_room && (wrap_left_q != '0);
	assign shift      = acc || wrap_issue;
	assign close_fire = (state_q == ST_CLOSE) && !valid_s1 && out_free;
	assign clear_seq  = close_fire;

	assign bmask      = base_set(base.base_char);
	assign shift_mask = acc ? bmask : head_q[ptr_q];

	// position of the window ending at the word entering now
	assign ovf_next   = ovf_q || (acc && count_q[POS_BITS]);
	assign count_next = count_q[POS_BITS] ? count_q : count_q + CNT_BITS'(1);
	assign idx_p1     = count_q + CNT_BITS'(1);
	assign pos_full   = idx_p1 - CNT_BITS'(act_len);
	assign elig_new   = (act_len != '0) && ((acc && ovf_next) || (idx_p1 >= CNT_BITS'(act_len)));
	assign pos_new    = (acc && ovf_next) ? POS_MAX : pos_full[POS_BITS-1:0];
	assign wrap_en    = circular_q && !ovf_next && (act_len != '0);
	assign ptr_p1     = CNT_BITS'(ptr_q) + CNT_BITS'(1);

	// count doubles as the virtual index while wrapping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			len_q   <= '0;
			ptr_q   <= '0;
		end else if (clear_seq) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			count_q <= count_next;
			ovf_q   <= ovf_next;
			len_q   <= count_next;
			ptr_q   <= '0;
		end else if (wrap_issue) begin
			count_q <= idx_p1;
			ptr_q   <= (ptr_p1 == len_q) ? '0 : ptr_p1[PTR_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (count_q < CNT_BITS'(HEAD_DEPTH)))
			head_q[count_q[PTR_BITS-1:0]] <= bmask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			elig_s1  <= 1'b0;
			ovf_s1   <= 1'b0;
			pos_s1   <= '0;
		end else if (shift) begin
			valid_s1 <= 1'b1;
			elig_s1  <= elig_new;
			ovf_s1   <= ovf_next;
			pos_s1   <= pos_new;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			wrap_left_q <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (acc && base.last_base) begin
						state_q     <= ST_WRAP;
						wrap_left_q <= wrap_en ? len_m1[PTR_BITS-1:0] : '0;
					end
				end
				ST_WRAP: begin
					if (wrap_left_q == '0)
						state_q <= ST_CLOSE;
					else if (wrap_issue)
						wrap_left_q <= wrap_left_q - PTR_BITS'(1);
				end
				ST_CLOSE: begin
					if (close_fire)
						state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase

			if (hit_s1 && out_free) begin
				out_valid_q           <= 1'b1;
				out_q.hit             <= 1'b1;
				out_q.start_position  <= pos_s1;
				out_q.run_done        <= 1'b0;
				out_q.length_overflow <= ovf_s1;
			end else if (close_fire) begin
				out_valid_q           <= 1'b1;
				out_q.hit             <= 1'b0;
				out_q.start_position  <= '0;
				out_q.run_done        <= 1'b1;
				out_q.length_overflow <= ovf_q;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* rtl/core/ipds_checker.sv */
module ipds_checker import ipds_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                base_valid,
	input logic                base_ready,
	input base_t               base,
	input logic                result_valid,
	input logic                result_ready,
	input result_t             result
);

	// held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_done_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.hit && result.run_done))
		else $error("hit and run_done together");

	a_miss_is_close: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.run_done && (result.start_position == '0))
		else $error("non-hit word that is not a closing word");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		base_valid && base_ready && base.last_base |=> !base_ready)
		else $error("base taken right after the last base");

endmodule

bind iupac_degenerate_pattern_search ipds_checker u_ipds_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import ipds_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                base_valid = 1'b0;
	logic                base_ready;
	base_t               base = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result;
	logic                cfg_we = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	iupac_degenerate_pattern_search uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// search model state and its copy of the pattern registers
	logic [63:0]       pat_lo = '0;
	logic [63:0]       pat_hi = '0;
	logic [5:0]        pat_len = 6'd1;
	logic              circ_on = 1'b0;
	logic [3:0]        win_sets [MAX_PATTERN];
	logic [3:0]        head_sets [HEAD_DEPTH];
	longint unsigned   seen_bases = 0;
	bit                seen_overflow = 0;

	result_t due_words [$];
	result_t want_word;
	int      errors = 0;
	int      burst_left = 0;
	int      hold_req = 0;
	int      stall_left = 0;
	int      pace_left = 0;
	int      stall_pct = 0;
	int      random_bases = 0;

	function automatic logic [3:0] nt_set(input logic [7:0] ch);
		logic [7:0] up;
		up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
		case (up)
			"A":      return SET_A;
			"C":      return SET_C;
			"G":      return SET_G;
			"T", "U": return SET_T;
			"R":      return SET_AG;
			"Y":      return SET_CT;
			"S":      return SET_CG;
			"W":      return SET_AT;
			"K":      return SET_GT;
			"M":      return SET_AC;
			"B":      return SET_CGT;
			"D":      return SET_AGT;
			"H":      return SET_ACT;
			"V":      return SET_ACG;
			"N":      return SET_ACGT;
			default:  return SET_NONE;
		endcase
	endfunction

	function automatic logic [3:0] sym_set(input int k);
		return (k < 16) ? pat_lo[k*4 +: 4] : pat_hi[(k-16)*4 +: 4];
	endfunction

	function automatic bit takes(input int k, input logic [3:0] b);
		return b != SET_NONE && (b & ~sym_set(k)) == SET_NONE;
	endfunction

	function automatic logic [3:0] seq_at(input longint unsigned j, input longint unsigned n);
		longint unsigned age;
		if (j < HEAD_DEPTH)
			return head_sets[j];
		age = n - 1 - j;
		return (age < MAX_PATTERN) ? win_sets[age] : SET_NONE;
	endfunction

	function automatic void clear_seq();
		foreach (win_sets[i]) win_sets[i] = SET_NONE;
		foreach (head_sets[i]) head_sets[i] = SET_NONE;
		seen_bases = 0;
		seen_overflow = 0;
	endfunction

	function automatic void push_word(input bit hit, input longint unsigned pos, input bit done);
		result_t w;
		w.hit = hit;
		w.start_position = pos[POS_BITS-1:0];
		w.run_done = done;
		w.length_overflow = seen_overflow;
		due_words = {due_words, w};
	endfunction

	// one base into the window; queues the words it causes
	function automatic void scan_base(input logic [7:0] ch, input bit last);
		logic [3:0]      b;
		int              m;
		int              i;
		int              k;
		longint unsigned idx;
		longint unsigned n;
		longint unsigned s;
		bit              ok;
		b = nt_set(ch);
		m = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
		idx = 0;
		if (seen_bases >= (64'd1 << POS_BITS)) begin
			seen_overflow = 1;
		end else begin
			idx = seen_bases;
			seen_bases++;
		end
		for (i = MAX_PATTERN - 1; i > 0; i--)
			win_sets[i] = win_sets[i-1];
		win_sets[0] = b;
		if (!seen_overflow && idx < HEAD_DEPTH)
			head_sets[idx] = b;
		if (m > 0 && (seen_overflow || idx + 1 >= m)) begin
			ok = 1;
			for (k = 0; k < m; k++)
				ok &= takes(k, win_sets[m-1-k]);
			if (ok)
				push_word(1, seen_overflow ? POS_MAX : idx + 1 - m, 0);
		end
		if (!last)
			return;
		if (circ_on && !seen_overflow && m > 0) begin
			n = seen_bases;
			s = (n + 1 > m) ? n + 1 - m : 0;
			while (s < n) begin
				ok = 1;
				for (k = 0; k < m; k++)
					ok &= takes(k, seq_at((s + k) % n, n));
				if (ok)
					push_word(1, s, 0);
				s++;
			end
		end
		push_word(0, 0, 1);
		clear_seq();
	endfunction

	function automatic logic [7:0] set_char(input logic [3:0] s);
		logic [7:0] c;
		case (s)
			SET_A:    c = "A";
			SET_C:    c = "C";
			SET_G:    c = "G";
			SET_T:    c = $urandom_range(0, 1) ? "U" : "T";
			SET_AG:   c = "R";
			SET_CT:   c = "Y";
			SET_CG:   c = "S";
			SET_AT:   c = "W";
			SET_GT:   c = "K";
			SET_AC:   c = "M";
			SET_CGT:  c = "B";
			SET_AGT:  c = "D";
			SET_ACT:  c = "H";
			SET_ACG:  c = "V";
			SET_ACGT: c = "N";
			default:  c = "X";
		endcase
		if ($urandom_range(0, 1))
			c = c | 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] noise_char();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'($urandom);
		if (r <= 3)
			return set_char(4'($urandom_range(0, 15)));
		return set_char(4'(1 << $urandom_range(0, 3)));
	endfunction

	// a base that symbol k accepts
	function automatic logic [7:0] fit_char(input int k);
		logic [3:0] mask;
		logic [3:0] s;
		mask = sym_set(k);
		if (mask == SET_NONE)
			return noise_char();
		do
			s = mask & 4'($urandom_range(1, 15));
		while (s == SET_NONE);
		return set_char(s);
	endfunction

	function automatic logic [63:0] rand_masks();
		logic [63:0] v;
		int          r;
		if ($urandom_range(0, 15) == 0)
			return {$urandom, $urandom};
		for (int i = 0; i < 16; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				v[i*4 +: 4] = 4'($urandom);
			else if (r <= 3)
				v[i*4 +: 4] = SET_ACGT;
			else
				v[i*4 +: 4] = 4'($urandom_range(1, 15));
		end
		return v;
	endfunction

	task automatic write_reg(input reg_index_t r, input logic [63:0] v);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (r)
			REG_MASKS_LOW:  pat_lo = v;
			REG_MASKS_HIGH: pat_hi = v;
			REG_LENGTH:     pat_len = v[5:0];
			REG_CIRCULAR:   circ_on = v[0];
		endcase
	endtask

	task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
			input logic [5:0] len, input logic circ);
		write_reg(REG_MASKS_LOW, lo);
		write_reg(REG_MASKS_HIGH, hi);
		write_reg(REG_LENGTH, 64'(len));
		write_reg(REG_CIRCULAR, 64'(circ));
	endtask

	// entered and left just after a falling edge
	task automatic send_base(input logic [7:0] ch, input logic last);
		if (burst_left == 0) begin
			base_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		base_valid = 1'b1;
		base.base_char = ch;
		base.last_base = last;
		do @(posedge clk); while (!base_ready);
		scan_base(ch, last);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		foreach (q[i])
			send_base(q[i], i == q.size() - 1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_base(s[i], i == s.len() - 1);
	endtask

	task automatic settle();
		base_valid = 1'b0;
		while (due_words.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_words.size() == 0) begin
				errors++;
				$display("%0t: word with none expected, got %p", $time, result);
			end else begin
				want_word = due_words.pop_front();
				check_field("hit", want_word.hit, result.hit);
				check_field("start_position", want_word.start_position, result.start_position);
				check_field("run_done", want_word.run_done, result.run_done);
				check_field("length_overflow", want_word.length_overflow,
					result.length_overflow);
			end
		end
	end

	// receiver: long hold on request, otherwise stall rate changes now and then
	always @(negedge clk) begin
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			result_ready = 1'b0;
			stall_left--;
		end else begin
			if (pace_left == 0) begin
				pace_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 70;
				endcase
			end
			pace_left--;
			result_ready = $urandom_range(0, 99) >= stall_pct;
		end
	end

	task automatic test_defaults();
		send_text("ACGT");
		settle();
	endtask

	task automatic test_codes();
		set_pattern({60'h0, SET_ACG}, '0, 6'd1, 1'b0);
		send_text("AcGtUrYsWkMbDhVn*");
		settle();
	endtask

	task automatic test_wrap();
		set_pattern({52'h0, SET_C, SET_A, SET_T}, '0, 6'd3, 1'b1);
		send_text("ACGT");
		settle();
		// pattern longer than the sequence
		set_pattern('1, '1, 6'd63, 1'b1);
		send_text("GA");
		settle();
	endtask

	task automatic test_zero_length();
		write_reg(REG_LENGTH, 64'd0);
		send_text("A");
		settle();
	endtask

	task automatic test_backpressure();
		set_pattern('1, '1, 6'd1, 1'b0);
		hold_req = 300;
		for (int i = 0; i < 40; i++)
			send_base(set_char(4'(1 << $urandom_range(0, 3))), i == 39);
		settle();
	endtask

	task automatic test_random();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [5:0]  len;
		logic [7:0]  q[$];
		int          m;
		int          n;
		while (random_bases < 260) begin
			lo = rand_masks();
			hi = rand_masks();
			case ($urandom_range(0, 9))
				0: len = 6'd0;
				1: len = 6'($urandom_range(32, 63));
				2: len = 6'($urandom_range(9, 31));
				default: len = 6'($urandom_range(1, 8));
			endcase
			set_pattern(lo, hi, len, 1'($urandom_range(0, 1)));
			m = (len > MAX_PATTERN) ? MAX_PATTERN : len;
			repeat ($urandom_range(1, 3)) begin
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 70)
					: $urandom_range(1, m + 6);
				q = {};
				while (q.size() < n) begin
					if (m > 0 && $urandom_range(0, 2) != 0) begin
						for (int k = 0; k < m && q.size() < n; k++)
							q = {q, fit_char(k)};
					end else begin
						q = {q, noise_char()};
					end
				end
				send_bytes(q);
				random_bases += n;
			end
			settle();
		end
	endtask

	initial begin
		clear_seq();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_defaults();
		test_codes();
		test_wrap();
		test_zero_length();
		test_backpressure();
		test_random();
		settle();
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
